// ===== src/bpt_pkg.sv =====
// Shared constants and control types for the bilinear pole transform.
package bpt_pkg;

  localparam logic [63:0]        GAIN_START_RST = 64'h0001_0000_0000_0000;
  localparam logic [30:0]        THRESH_RST     = 31'd1;
  localparam logic [63:0]        ONE_Q48        = 64'h0001_0000_0000_0000;
  localparam logic signed [33:0] ONE_Q24        = 34'sd16777216;
  localparam logic [63:0]        MAX32          = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0]        MAX64          = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned        DIV_STEPS      = 64;

  typedef enum logic {
    REG_GAIN_START     = 1'b0,
    REG_REAL_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SQ_AR,
    SQ_UI,
    SQ_UR
  } sq_sel_t;

  typedef struct packed {
    logic    capture;
    logic    sq_en;
    sq_sel_t sq_sel;
    logic    sum;
    logic    prep;
    logic    load;
    logic    step;
    logic    clamp;
    logic    commit;
  } bpt_cmd_t;

  typedef struct packed {
    logic is_real;
  } bpt_status_t;

endpackage

// ===== src/bpt_div_lane.sv =====
// One restoring divider lane with zero-divisor and saturation handling.
module bpt_div_lane (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic        active_in,
  input  logic        neg_in,
  input  logic [63:0] mag_in,
  input  logic [63:0] hi_in,
  input  logic [63:0] lo_in,
  input  logic [63:0] den_in,
  input  logic [63:0] posmax_in,
  input  logic        step,
  input  logic        clamp,
  output logic [63:0] result,
  output logic        sat
);

  logic        active;
  logic        fixed;
  logic        sat_r;
  logic        out_neg;
  logic [63:0] q;
  logic [63:0] rem;
  logic [63:0] lo;
  logic [63:0] den;
  logic [63:0] lim;

  logic [63:0] lim_w;
  logic        fixed_w;
  logic        sat_w;
  logic        neg_w;
  logic [63:0] q_init;
  logic [64:0] rem_sh;
  logic [64:0] diff;
  logic        fits;

  assign lim_w = posmax_in + {63'd0, neg_in};

  // The quotient is settled at load time when the divisor is zero, the
  // dividend is zero, or the upper half already reaches the divisor.
  always_comb begin
    fixed_w = 1'b1;
    sat_w   = 1'b0;
    neg_w   = neg_in;
    q_init  = '0;
    if (den_in == '0) begin
      sat_w  = 1'b1;
      neg_w  = neg_in && (mag_in != '0);
      q_init = (mag_in != '0) ? lim_w : posmax_in;
    end else if (mag_in == '0) begin
      q_init = '0;
    end else if (hi_in >= den_in) begin
      sat_w  = 1'b1;
      q_init = lim_w;
    end else begin
      fixed_w = 1'b0;
    end
  end

  assign rem_sh = {rem, lo[63]};
  assign diff   = rem_sh - {1'b0, den};
  assign fits   = !diff[64];

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      fixed   <= 1'b0;
      sat_r   <= 1'b0;
      out_neg <= 1'b0;
    end else if (load) begin
      active  <= active_in;
      fixed   <= fixed_w;
      sat_r   <= sat_w;
      out_neg <= neg_w;
    end else if (clamp && !fixed && (q > lim)) begin
      sat_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q   <= q_init;
      rem <= hi_in;
      lo  <= lo_in;
      den <= den_in;
      lim <= lim_w;
    end else if (step && !fixed) begin
      rem <= fits ? diff[63:0] : rem_sh[63:0];
      lo  <= {lo[62:0], 1'b0};
      q   <= {q[62:0], fits};
    end else if (clamp && !fixed && (q > lim)) begin
      q <= lim;
    end
  end

  assign result = active ? (out_neg ? (64'd0 - q) : q) : '0;
  assign sat    = active && sat_r;

endmodule

// ===== src/bpt_datapath.sv =====
// Datapath: configuration, running gain, squarer, operand preparation and divider lanes.
module bpt_datapath
  import bpt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic signed [31:0] pole_re,
  input  logic signed [31:0] pole_im,
  input  logic               first,
  input  logic               last,
  input  bpt_cmd_t           cmd,
  output bpt_status_t        status,
  output logic signed [31:0] zpole_re,
  output logic signed [31:0] zpole_im,
  output logic signed [63:0] gain,
  output logic               done_res,
  output logic               saturated
);

  logic [63:0]        gain_start;
  logic [30:0]        real_threshold;
  logic [63:0]        running_gain;

  logic signed [31:0] re_r;
  logic               im_neg;
  logic [31:0]        ar;
  logic [31:0]        ur;
  logic [31:0]        ui;
  logic               last_r;
  logic               is_real;
  logic               gain_neg;
  logic [63:0]        gain_mag;

  logic [63:0]        sq_ar;
  logic [63:0]        sq_ui;
  logic [63:0]        sq_ur;
  logic [63:0]        d;
  logic [63:0]        s2;

  logic [63:0]        num_mag;
  logic               num_neg;
  logic [63:0]        den_mag;
  logic               den_neg;

  // Capture-side combinational values.
  logic signed [33:0] re_ext;
  logic signed [33:0] im_ext;
  logic signed [33:0] ar_s;
  logic signed [33:0] ar_abs;
  logic signed [33:0] ur_abs;
  logic signed [33:0] ui_abs;
  logic [63:0]        gain_sel;

  // Real-pole operands taken from the captured pole.
  logic signed [33:0] re_cap_ext;
  logic signed [33:0] rnum;
  logic signed [33:0] rden;
  logic signed [33:0] rnum_abs;
  logic signed [33:0] rden_abs;

  logic [31:0]        sq_op;
  logic [63:0]        sq_prod;

  logic [63:0]        lane_hi [3];
  logic [63:0]        lane_lo [3];
  logic [63:0]        lane_res [3];
  logic               lane_sat [3];

  assign re_ext   = {{2{pole_re[31]}}, pole_re};
  assign im_ext   = {{2{pole_im[31]}}, pole_im};
  assign ar_s     = ONE_Q24 - re_ext;
  assign ar_abs   = ar_s[33] ? (34'sd0 - ar_s) : ar_s;
  assign ur_abs   = re_ext[33] ? (34'sd0 - re_ext) : re_ext;
  assign ui_abs   = im_ext[33] ? (34'sd0 - im_ext) : im_ext;
  assign gain_sel = first ? gain_start : running_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_start     <= GAIN_START_RST;
      real_threshold <= THRESH_RST;
      running_gain   <= '0;
      is_real        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_GAIN_START:     gain_start     <= cfg_data;
          REG_REAL_THRESHOLD: real_threshold <= cfg_data[30:0];
          default:            gain_start     <= gain_start;
        endcase
      end
      if (cmd.capture) begin
        is_real <= ($unsigned(ui_abs[31:0]) <= {1'b0, real_threshold});
      end
      if (cmd.commit) begin
        running_gain <= lane_res[2];
      end
    end
  end

  assign status.is_real = is_real;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      re_r     <= pole_re;
      im_neg   <= pole_im[31];
      ar       <= ar_abs[31:0];
      ur       <= ur_abs[31:0];
      ui       <= ui_abs[31:0];
      last_r   <= last;
      gain_neg <= gain_sel[63];
      gain_mag <= gain_sel[63] ? (64'd0 - gain_sel) : gain_sel;
    end
  end

  // One shared squarer; each product lands in its own register.
  always_comb begin
    case (cmd.sq_sel)
      SQ_AR:   sq_op = ar;
      SQ_UI:   sq_op = ui;
      SQ_UR:   sq_op = ur;
      default: sq_op = '0;
    endcase
  end

  assign sq_prod = {32'd0, sq_op} * {32'd0, sq_op};

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      case (cmd.sq_sel)
        SQ_AR:   sq_ar <= sq_prod;
        SQ_UI:   sq_ui <= sq_prod;
        SQ_UR:   sq_ur <= sq_prod;
        default: sq_ar <= sq_ar;
      endcase
    end
    if (cmd.sum) begin
      d  <= sq_ar + sq_ui;
      s2 <= sq_ur + sq_ui;
    end
  end

  assign re_cap_ext = {{2{re_r[31]}}, re_r};
  assign rnum       = ONE_Q24 + re_cap_ext;
  assign rden       = ONE_Q24 - re_cap_ext;
  assign rnum_abs   = rnum[33] ? (34'sd0 - rnum) : rnum;
  assign rden_abs   = rden[33] ? (34'sd0 - rden) : rden;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      if (is_real) begin
        num_mag <= {30'd0, $unsigned(rnum_abs)};
        num_neg <= rnum[33];
        den_mag <= {30'd0, $unsigned(rden_abs)};
        den_neg <= rden[33];
      end else begin
        num_neg <= (s2 > ONE_Q48);
        num_mag <= (s2 > ONE_Q48) ? (s2 - ONE_Q48) : (ONE_Q48 - s2);
        den_mag <= d;
        den_neg <= 1'b0;
      end
    end
  end

  // The real part is scaled by 2^24, the imaginary part by 2^49, and the
  // gain by 2^24 for a real pole or 2^48 for a complex one.
  assign lane_hi[0] = {40'd0, num_mag[63:40]};
  assign lane_lo[0] = {num_mag[39:0], 24'd0};
  assign lane_hi[1] = {47'd0, ui[31:15]};
  assign lane_lo[1] = {ui[14:0], 49'd0};
  assign lane_hi[2] = is_real ? {40'd0, gain_mag[63:40]} : {16'd0, gain_mag[63:16]};
  assign lane_lo[2] = is_real ? {gain_mag[39:0], 24'd0} : {gain_mag[15:0], 48'd0};

  bpt_div_lane u_lane_re (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd.load),
    .active_in (1'b1),
    .neg_in    (num_neg ^ den_neg),
    .mag_in    (num_mag),
    .hi_in     (lane_hi[0]),
    .lo_in     (lane_lo[0]),
    .den_in    (den_mag),
    .posmax_in (MAX32),
    .step      (cmd.step),
    .clamp     (cmd.clamp),
    .result    (lane_res[0]),
    .sat       (lane_sat[0])
  );

  bpt_div_lane u_lane_im (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd.load),
    .active_in (!is_real),
    .neg_in    (im_neg),
    .mag_in    ({32'd0, ui}),
    .hi_in     (lane_hi[1]),
    .lo_in     (lane_lo[1]),
    .den_in    (den_mag),
    .posmax_in (MAX32),
    .step      (cmd.step),
    .clamp     (cmd.clamp),
    .result    (lane_res[1]),
    .sat       (lane_sat[1])
  );

  bpt_div_lane u_lane_gain (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd.load),
    .active_in (1'b1),
    .neg_in    (gain_neg ^ den_neg),
    .mag_in    (gain_mag),
    .hi_in     (lane_hi[2]),
    .lo_in     (lane_lo[2]),
    .den_in    (den_mag),
    .posmax_in (MAX64),
    .step      (cmd.step),
    .clamp     (cmd.clamp),
    .result    (lane_res[2]),
    .sat       (lane_sat[2])
  );

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      zpole_re  <= lane_res[0][31:0];
      zpole_im  <= lane_res[1][31:0];
      gain      <= lane_res[2];
      done_res  <= last_r;
      saturated <= lane_sat[0] | lane_sat[1] | lane_sat[2];
    end
  end

endmodule

// ===== src/bpt_ctrl.sv =====
// Controller: sequences squaring, operand preparation, division and the output register.
module bpt_ctrl
  import bpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  bpt_status_t status,
  output bpt_cmd_t    cmd
);

  localparam int unsigned     CNT_W    = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_AR,
    S_SQ_UI,
    S_SQ_UR,
    S_SUM,
    S_PREP,
    S_LOAD,
    S_DIV,
    S_CLAMP,
    S_OUT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic             out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.sq_sel  = SQ_AR;
    cmd.capture = (state == S_IDLE) && in_valid;
    unique case (state)
      S_SQ_AR: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_AR;
      end
      S_SQ_UI: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_UI;
      end
      S_SQ_UR: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_UR;
      end
      S_SUM:   cmd.sum    = 1'b1;
      S_PREP:  cmd.prep   = 1'b1;
      S_LOAD:  cmd.load   = 1'b1;
      S_DIV:   cmd.step   = 1'b1;
      S_CLAMP: cmd.clamp  = 1'b1;
      S_OUT:   cmd.commit = out_free;
      default: cmd.sum    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SQ_AR;
          end
        end
        // A real pole needs no squares; the first one is simply discarded.
        S_SQ_AR: state <= status.is_real ? S_PREP : S_SQ_UI;
        S_SQ_UI: state <= S_SQ_UR;
        S_SQ_UR: state <= S_SUM;
        S_SUM:   state <= S_PREP;
        S_PREP:  state <= S_LOAD;
        S_LOAD: begin
          count <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          count <= count + 1'b1;
          if (count == CNT_LAST) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/bilinear_pole_transform_core.sv =====
// A request is captured, squared (complex pole only), prepared, divided and clamped before its result is committed.
// No new request is taken until the current pole is committed; the dividers run 64 steps per pole.
// A new request is taken while the previous result still waits in the output register.
// Synchronous reset: gain_start returns to 1.0, real_threshold to 1, the running gain to zero.
// The running gain is reloaded from gain_start on a pole flagged first.
module bilinear_pole_transform_core
  import bpt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pole_re,
  input  logic signed [31:0] pole_im,
  input  logic               first,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] zpole_re,
  output logic signed [31:0] zpole_im,
  output logic signed [63:0] gain,
  output logic               done_res,
  output logic               saturated
);

  bpt_cmd_t    cmd;
  bpt_status_t status;

  bpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bpt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pole_re   (pole_re),
    .pole_im   (pole_im),
    .first     (first),
    .last      (last),
    .cmd       (cmd),
    .status    (status),
    .zpole_re  (zpole_re),
    .zpole_im  (zpole_im),
    .gain      (gain),
    .done_res  (done_res),
    .saturated (saturated)
  );

  // Once a request is taken, no further request is accepted until its result is out.
  assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a pole is in progress");

  // A committed result is presented and the block is ready for the next request.
  assert property (@(posedge clk) disable iff (rst) cmd.commit |=> out_valid && in_ready)
    else $error("committed result not presented");

  // A real pole always leaves a zero imaginary part.
  assert property (@(posedge clk) disable iff (rst)
                   cmd.commit && status.is_real |=> zpole_im == 32'sd0)
    else $error("real pole produced a non-zero imaginary part");

endmodule
